/* rtl/core/sdc_pkg.sv */
package sdc_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int MAX_RES     = 16;
    localparam int CNT_W       = $clog2(MAX_RES + 1);

    typedef enum logic [1:0] {
        MODE_INIT  = 2'd0,
        MODE_OPEN  = 2'd1,
        MODE_CLOSE = 2'd2,
        MODE_BYTE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ACT_DESEL = 3'd0,
        ACT_SEL   = 3'd1,
        ACT_SEND  = 3'd2,
        ACT_RECV  = 3'd3,
        ACT_DONE  = 3'd4
    } act_t;

    typedef enum logic [1:0] {
        REG_WAIT  = 2'd0,
        REG_RETRY = 2'd1,
        REG_INIT  = 2'd2,
        REG_RST   = 2'd3
    } reg_idx_t;

    typedef enum logic [14:0] {
        PH_IDLE       = 15'b000000000000001,
        PH_CMD0       = 15'b000000000000010,
        PH_CMD8       = 15'b000000000000100,
        PH_V2_55      = 15'b000000000001000,
        PH_V2_41      = 15'b000000000010000,
        PH_CMD58      = 15'b000000000100000,
        PH_OCR        = 15'b000000001000000,
        PH_V1_55A     = 15'b000000010000000,
        PH_V1_41A     = 15'b000000100000000,
        PH_V1_55      = 15'b000001000000000,
        PH_V1_41      = 15'b000010000000000,
        PH_V1_CMD1    = 15'b000100000000000,
        PH_OPEN_STOP  = 15'b001000000000000,
        PH_OPEN_READ  = 15'b010000000000000,
        PH_CLOSE_STOP = 15'b100000000000000
    } phase_t;

    localparam logic [7:0] OP_CMD0  = 8'h40;
    localparam logic [7:0] OP_CMD1  = 8'h41;
    localparam logic [7:0] OP_CMD8  = 8'h48;
    localparam logic [7:0] OP_CMD12 = 8'h4C;
    localparam logic [7:0] OP_CMD18 = 8'h52;
    localparam logic [7:0] OP_CMD41 = 8'h69;
    localparam logic [7:0] OP_CMD55 = 8'h77;
    localparam logic [7:0] OP_CMD58 = 8'h7A;
    localparam logic [7:0] CRC_CMD0 = 8'h95;
    localparam logic [7:0] CRC_CMD8 = 8'h87;
    localparam logic [7:0] IDLE_BYTE = 8'hFF;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_CMD8      = 4'd1;
    localparam logic [3:0] ST_V2_55     = 4'd2;
    localparam logic [3:0] ST_V2_41     = 4'd3;
    localparam logic [3:0] ST_V2_LOOP   = 4'd4;
    localparam logic [3:0] ST_CMD58     = 4'd5;
    localparam logic [3:0] ST_V1_55A    = 4'd6;
    localparam logic [3:0] ST_V1_41A    = 4'd7;
    localparam logic [3:0] ST_V1_55     = 4'd8;
    localparam logic [3:0] ST_V1_41     = 4'd9;
    localparam logic [3:0] ST_OPEN_FAIL = 4'd11;

    typedef struct packed {
        act_t       action;
        logic [7:0] tx_byte;
        logic [7:0] repeat_res;
        logic [3:0] status;
        logic [1:0] card_type;
    } res_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  rx_byte;
        logic [31:0] sector_address;
        logic [15:0] block_count;
    } item_t;

    typedef struct packed {
        logic [9:0] wait_limit;
        logic [9:0] retry_limit;
        logic [3:0] init_attempts;
        logic [3:0] reset_attempts;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  card_kind;
        logic        read_open;
        logic [31:0] cur_sector;
        logic [31:0] pend_sector;
        logic [15:0] pend_count;
        logic [9:0]  poll_cnt;
        logic [9:0]  loop_cnt;
        logic [3:0]  attempt_cnt;
        logic [3:0]  rtry_cnt;
        logic [7:0]  last_reply;
    } st_t;

    typedef struct packed {
        st_t                      s;
        res_t [MAX_RES-1:0]       r;
        logic [CNT_W-1:0]         n;
    } ctx_t;

endpackage

/* rtl/core/sdc_req_if.sv */
interface sdc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  rx_byte;
    logic [31:0] sector_address;
    logic [15:0] block_count;

    modport source (output valid, mode, rx_byte, sector_address, block_count, input ready);
    modport sink (input valid, mode, rx_byte, sector_address, block_count, output ready);
endinterface

interface sdc_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic [7:0] repeat_res;
    logic [3:0] status;
    logic [1:0] card_type;
    logic       last;

    modport source (output valid, action, tx_byte, repeat_res, status, card_type, last,
                    input ready);
    modport sink (input valid, action, tx_byte, repeat_res, status, card_type, last,
                  output ready);
endinterface

/* rtl/core/sd_card_spi_command_controller_top.sv */
// SD card SPI-mode command sequencer.
// req (sink): host requests (mode 0 init, 1 open read, 2 close) and bytes
//   received from the card (mode 3). rsp (source): SPI actions to perform,
//   one per item: deselect, select, send byte with repeat count, receive
//   byte, or request done with status and card type; last marks the final
//   action caused by one request item.
// cfg_we / cfg_index / cfg_data: register writes, taken at any edge with
//   cfg_we high; write only while the block is idle.
// Path: an item is accepted into the input register, then its actions are
//   loaded into the result batch register once it is free; rsp presents them.
// Throughput: one item per cycle while each item gives at most one action and
//   rsp does not stall; an item giving n actions (up to 16) holds the batch
//   register until all n are taken, one action per accepted rsp item.
// A stalled rsp holds its action; req keeps accepting into the input
//   register until it fills, then ready drops.
// Reset: phase idle, card kind zero, no read open, registers at defaults
//   (wait 512, retry 256, init attempts 4, reset attempts 8).
module sd_card_spi_command_controller_top (
    input  logic               clk,
    input  logic               rst_n,
    sdc_req_if.sink            req,
    sdc_rsp_if.source          rsp,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [9:0]         cfg_data
);
    import sdc_pkg::*;

    function automatic ctx_t f_emit(ctx_t c, act_t a, logic [7:0] tx, logic [7:0] rep,
                                    logic [3:0] st, logic [1:0] ct);
        res_t e;
        e.action     = a;
        e.tx_byte    = tx;
        e.repeat_res = rep;
        e.status     = st;
        e.card_type  = ct;
        if (c.n < CNT_W'(MAX_RES))
        begin
            c.r[c.n[CNT_W-2:0]] = e;
            c.n = c.n + CNT_W'(1);
        end
        return c;
    endfunction

    function automatic ctx_t f_act(ctx_t c, act_t a);
        return f_emit(c, a, 8'd0, 8'd1, 4'd0, 2'd0);
    endfunction

    function automatic ctx_t f_send(ctx_t c, logic [7:0] b, logic [7:0] rep);
        return f_emit(c, ACT_SEND, b, rep, 4'd0, 2'd0);
    endfunction

    function automatic ctx_t f_finish(ctx_t c, logic [3:0] st);
        ctx_t o;
        o = f_emit(c, ACT_DONE, 8'd0, 8'd1, st, c.s.card_kind);
        o.s.phase = PH_IDLE;
        return o;
    endfunction

    function automatic ctx_t f_command(ctx_t c, logic [7:0] op, logic [31:0] arg, phase_t nxt);
        logic [7:0] crc;
        crc = 8'd0;
        if (op == OP_CMD8)
            crc = CRC_CMD8;
        if (op == OP_CMD0)
            crc = CRC_CMD0;
        c = f_act(c, ACT_SEL);
        c = f_send(c, IDLE_BYTE, 8'd1);
        c = f_send(c, op, 8'd1);
        c = f_send(c, arg[31:24], 8'd1);
        c = f_send(c, arg[23:16], 8'd1);
        c = f_send(c, arg[15:8], 8'd1);
        c = f_send(c, arg[7:0], 8'd1);
        c = f_send(c, crc, 8'd1);
        c = f_send(c, IDLE_BYTE, 8'd1);
        c = f_act(c, ACT_RECV);
        c.s.poll_cnt = 10'd0;
        c.s.phase = nxt;
        return c;
    endfunction

    function automatic ctx_t f_reset_step(ctx_t c, cfg_t g);
        if (c.s.rtry_cnt < g.reset_attempts)
        begin
            c.s.rtry_cnt = c.s.rtry_cnt + 4'd1;
            c = f_command(c, OP_CMD0, 32'd0, PH_CMD0);
        end
        else
        begin
            c = f_send(c, IDLE_BYTE, 8'd2);
            c = f_command(c, OP_CMD8, 32'h1AA, PH_CMD8);
        end
        return c;
    endfunction

    function automatic ctx_t f_start(ctx_t c, cfg_t g);
        c.s.card_kind = 2'd0;
        c.s.read_open = 1'b0;
        c = f_act(c, ACT_DESEL);
        c = f_send(c, IDLE_BYTE, 8'd128);
        c.s.rtry_cnt = 4'd0;
        return f_reset_step(c, g);
    endfunction

    function automatic ctx_t f_fail(ctx_t c, cfg_t g, logic [3:0] code);
        logic [3:0] lim;
        lim = (g.init_attempts == 4'd0) ? 4'd1 : g.init_attempts;
        c.s.attempt_cnt = c.s.attempt_cnt + 4'd1;
        if (c.s.attempt_cnt < lim)
            c = f_start(c, g);
        else
            c = f_finish(c, code);
        return c;
    endfunction

    function automatic ctx_t f_v2_pass(ctx_t c, cfg_t g);
        if (c.s.loop_cnt >= g.retry_limit)
            return f_fail(c, g, ST_V2_LOOP);
        c.s.loop_cnt = c.s.loop_cnt + 10'd1;
        return f_command(c, OP_CMD55, 32'h0000FFFF, PH_V2_55);
    endfunction

    function automatic ctx_t f_v1_pass(ctx_t c, cfg_t g);
        if (c.s.loop_cnt >= g.retry_limit)
            return f_finish(c, ST_OK);
        c.s.loop_cnt = c.s.loop_cnt + 10'd1;
        if (c.s.last_reply == 8'd0)
            return f_command(c, OP_CMD55, 32'd0, PH_V1_55);
        return f_command(c, OP_CMD1, 32'd0, PH_V1_CMD1);
    endfunction

    function automatic ctx_t f_issue_read(ctx_t c);
        logic [31:0] addr;
        addr = c.s.pend_sector;
        c.s.cur_sector = c.s.pend_sector;
        // standard-capacity cards take byte addresses
        if (!c.s.card_kind[0])
            addr = c.s.pend_sector << BLOCK_SHIFT;
        return f_command(c, OP_CMD18, addr, PH_OPEN_READ);
    endfunction

    function automatic ctx_t f_on_reply(ctx_t c, cfg_t g, logic [7:0] r);
        case (c.s.phase)
            PH_CMD0:
            begin
                if (r == 8'd1)
                    c = f_command(c, OP_CMD8, 32'h1AA, PH_CMD8);
                else
                    c = f_reset_step(c, g);
            end
            PH_CMD8:
            begin
                c = f_send(c, IDLE_BYTE, 8'd5);
                if (r == IDLE_BYTE)
                    c = f_fail(c, g, ST_CMD8);
                else if (r != 8'd5)
                begin
                    c.s.card_kind = 2'd2;
                    c.s.loop_cnt = 10'd0;
                    c = f_v2_pass(c, g);
                end
                else
                    c = f_command(c, OP_CMD55, 32'd0, PH_V1_55A);
            end
            PH_V2_55:
            begin
                if (r == IDLE_BYTE)
                    c = f_fail(c, g, ST_V2_55);
                else if (r != 8'd1)
                    c = f_v2_pass(c, g);
                else
                    c = f_command(c, OP_CMD41, 32'h40300000, PH_V2_41);
            end
            PH_V2_41:
            begin
                if (r == IDLE_BYTE)
                    c = f_fail(c, g, ST_V2_41);
                else if (r != 8'd0)
                    c = f_v2_pass(c, g);
                else
                    c = f_command(c, OP_CMD58, 32'd0, PH_CMD58);
            end
            PH_CMD58:
            begin
                if (r == IDLE_BYTE)
                    c = f_fail(c, g, ST_CMD58);
                else
                begin
                    c = f_act(c, ACT_SEL);
                    c = f_act(c, ACT_RECV);
                    c.s.phase = PH_OCR;
                end
            end
            PH_V1_55A:
            begin
                if (r == IDLE_BYTE)
                    c = f_fail(c, g, ST_V1_55A);
                else
                    c = f_command(c, OP_CMD41, 32'd0, PH_V1_41A);
            end
            PH_V1_41A:
            begin
                if (r == IDLE_BYTE)
                    c = f_fail(c, g, ST_V1_41A);
                else
                begin
                    c.s.loop_cnt = 10'd0;
                    c = f_v1_pass(c, g);
                end
            end
            PH_V1_55:
            begin
                if (r == IDLE_BYTE)
                    c = f_fail(c, g, ST_V1_55);
                else if (r != 8'd1)
                    c = f_v1_pass(c, g);
                else
                    c = f_command(c, OP_CMD41, 32'd0, PH_V1_41);
            end
            PH_V1_41:
            begin
                if (r == IDLE_BYTE)
                    c = f_fail(c, g, ST_V1_41);
                else if (r != 8'd0)
                    c = f_v1_pass(c, g);
                else
                    c = f_finish(c, ST_OK);
            end
            PH_V1_CMD1:
            begin
                if (r != 8'd0)
                    c = f_v1_pass(c, g);
                else
                    c = f_finish(c, ST_OK);
            end
            PH_OPEN_STOP:
            begin
                c.s.read_open = 1'b0;
                c = f_issue_read(c);
            end
            PH_OPEN_READ:
            begin
                if (r != 8'd0)
                    c = f_finish(c, ST_OPEN_FAIL);
                else
                begin
                    c = f_act(c, ACT_SEL);
                    c.s.read_open = 1'b1;
                    c.s.cur_sector = c.s.cur_sector + {16'd0, c.s.pend_count};
                    c = f_finish(c, ST_OK);
                end
            end
            PH_CLOSE_STOP:
            begin
                c.s.read_open = 1'b0;
                c = f_finish(c, ST_OK);
            end
            default:
            begin
                c.s.phase = PH_IDLE;
            end
        endcase
        return c;
    endfunction

    function automatic ctx_t f_step(st_t s, cfg_t g, item_t it);
        ctx_t c;
        c.s = s;
        c.r = '0;
        c.n = '0;
        if (it.mode == MODE_BYTE)
        begin
            if (c.s.phase == PH_OCR)
            begin
                c = f_send(c, IDLE_BYTE, 8'd3);
                if (it.rx_byte[6])
                    c.s.card_kind[0] = 1'b1;
                c = f_finish(c, ST_OK);
            end
            else if (c.s.phase != PH_IDLE)
            begin
                if (it.rx_byte == IDLE_BYTE && c.s.poll_cnt < g.wait_limit)
                begin
                    c.s.poll_cnt = c.s.poll_cnt + 10'd1;
                    c = f_act(c, ACT_RECV);
                end
                else
                begin
                    c = f_act(c, ACT_DESEL);
                    c.s.last_reply = it.rx_byte;
                    c = f_on_reply(c, g, it.rx_byte);
                end
            end
        end
        else if (c.s.phase == PH_IDLE)
        begin
            if (it.mode == MODE_INIT)
            begin
                c.s.attempt_cnt = 4'd0;
                c = f_start(c, g);
            end
            else if (it.mode == MODE_OPEN)
            begin
                c.s.pend_sector = it.sector_address;
                c.s.pend_count = it.block_count;
                if (c.s.read_open && it.sector_address == c.s.cur_sector)
                begin
                    c.s.cur_sector = c.s.cur_sector + {16'd0, it.block_count};
                    c = f_finish(c, ST_OK);
                end
                else if (c.s.read_open)
                begin
                    c = f_act(c, ACT_DESEL);
                    c = f_command(c, OP_CMD12, 32'd0, PH_OPEN_STOP);
                end
                else
                    c = f_issue_read(c);
            end
            else
            begin
                if (!c.s.read_open)
                    c = f_finish(c, ST_OK);
                else
                begin
                    c = f_act(c, ACT_DESEL);
                    c = f_command(c, OP_CMD12, 32'd0, PH_CLOSE_STOP);
                end
            end
        end
        return c;
    endfunction

    cfg_t               cfg_reg;
    st_t                st_reg;
    logic               in_v_reg;
    item_t              in_reg;
    res_t [MAX_RES-1:0] batch_reg;
    logic [CNT_W-1:0]   batch_n_reg;

    ctx_t               step;
    logic               take;
    logic               batch_free;
    logic               load;
    logic               in_take;

    always_comb
    begin
        step = f_step(st_reg, cfg_reg, in_reg);
    end

    assign take       = rsp.valid && rsp.ready;
    assign batch_free = (batch_n_reg == '0) || (batch_n_reg == CNT_W'(1) && take);
    assign load       = in_v_reg && batch_free;
    assign req.ready  = !in_v_reg || load;
    assign in_take    = req.valid && req.ready;

    assign rsp.valid      = (batch_n_reg != '0);
    assign rsp.action     = batch_reg[0].action;
    assign rsp.tx_byte    = batch_reg[0].tx_byte;
    assign rsp.repeat_res = batch_reg[0].repeat_res;
    assign rsp.status     = batch_reg[0].status;
    assign rsp.card_type  = batch_reg[0].card_type;
    assign rsp.last       = (batch_n_reg == CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wait_limit     <= 10'd512;
            cfg_reg.retry_limit    <= 10'd256;
            cfg_reg.init_attempts  <= 4'd4;
            cfg_reg.reset_attempts <= 4'd8;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_WAIT:  cfg_reg.wait_limit     <= cfg_data;
                REG_RETRY: cfg_reg.retry_limit    <= cfg_data;
                REG_INIT:  cfg_reg.init_attempts  <= cfg_data[3:0];
                REG_RST:   cfg_reg.reset_attempts <= cfg_data[3:0];
                default:   cfg_reg.wait_limit     <= cfg_reg.wait_limit;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg    <= 1'b0;
            batch_n_reg <= '0;
            st_reg      <= {PH_IDLE, ($bits(st_t) - $bits(phase_t))'(0)};
        end
        else
        begin
            if (in_take)
                in_v_reg <= 1'b1;
            else if (load)
                in_v_reg <= 1'b0;
            if (load)
            begin
                st_reg      <= step.s;
                batch_n_reg <= step.n;
            end
            else if (take)
                batch_n_reg <= batch_n_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg.mode           <= mode_t'(req.mode);
            in_reg.rx_byte        <= req.rx_byte;
            in_reg.sector_address <= req.sector_address;
            in_reg.block_count    <= req.block_count;
        end
        if (load)
            batch_reg <= step.r;
        else if (take)
        begin
            // advance the queue by one action
            for (int i = 0; i < MAX_RES - 1; i++)
                batch_reg[i] <= batch_reg[i+1];
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        batch_n_reg <= CNT_W'(MAX_RES))
        else $error("batch count over capacity");
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.action == ACT_DONE |-> rsp.last)
        else $error("done action not last of its item");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        take && batch_n_reg > CNT_W'(1) |=> rsp.valid)
        else $error("batch dropped before drained");
    a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_v_reg && !batch_free |=> in_v_reg && $stable(in_reg))
        else $error("pending item lost");
`endif

endmodule
